### rtl/stl_pkg.sv
`timescale 1ns / 1ps

package stl_pkg;

   localparam int POS_W       = 16;
   localparam int CH_W        = 8;
   localparam int KIND_W      = 3;
   localparam int CODE_W      = 5;
   localparam int KW_MAX_LEN  = 8;
   localparam int KW_IDX_W    = $clog2(KW_MAX_LEN);
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
   localparam int RSP_DATA_W  = 40;
   localparam int REQ_DATA_W  = 8;

   localparam logic [KIND_W-1:0] KIND_OP   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SPEC = 3'd1;
   localparam logic [KIND_W-1:0] KIND_KW   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NAME = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

   localparam logic [CODE_W-1:0] KW_IF       = 5'd0;
   localparam logic [CODE_W-1:0] KW_FOR      = 5'd1;
   localparam logic [CODE_W-1:0] KW_FUNCTION = 5'd2;
   localparam logic [CODE_W-1:0] KW_CLASS    = 5'd3;
   localparam logic [CODE_W-1:0] CODE_NONE   = 5'd0;

   localparam logic [CODE_W-1:0] OP_ADD    = 5'd0;
   localparam logic [CODE_W-1:0] OP_SUB    = 5'd1;
   localparam logic [CODE_W-1:0] OP_MUL    = 5'd2;
   localparam logic [CODE_W-1:0] OP_DIV    = 5'd3;
   localparam logic [CODE_W-1:0] OP_ASSIGN = 5'd4;
   localparam logic [CODE_W-1:0] OP_INC    = 5'd5;
   localparam logic [CODE_W-1:0] OP_DEC    = 5'd6;
   localparam logic [CODE_W-1:0] OP_ADD_EQ = 5'd7;
   localparam logic [CODE_W-1:0] OP_SUB_EQ = 5'd8;
   localparam logic [CODE_W-1:0] OP_MUL_EQ = 5'd9;
   localparam logic [CODE_W-1:0] OP_DIV_EQ = 5'd10;
   localparam logic [CODE_W-1:0] OP_AND    = 5'd11;
   localparam logic [CODE_W-1:0] OP_OR     = 5'd12;
   localparam logic [CODE_W-1:0] OP_NOT    = 5'd13;
   localparam logic [CODE_W-1:0] OP_GT     = 5'd14;
   localparam logic [CODE_W-1:0] OP_LT     = 5'd15;
   localparam logic [CODE_W-1:0] OP_GE     = 5'd16;
   localparam logic [CODE_W-1:0] OP_LE     = 5'd17;
   localparam logic [CODE_W-1:0] OP_NE     = 5'd18;
   localparam logic [CODE_W-1:0] OP_EQ     = 5'd19;

   localparam logic [CODE_W-1:0] SP_DOT     = 5'd0;
   localparam logic [CODE_W-1:0] SP_COMMA   = 5'd1;
   localparam logic [CODE_W-1:0] SP_LPAREN  = 5'd2;
   localparam logic [CODE_W-1:0] SP_RPAREN  = 5'd3;
   localparam logic [CODE_W-1:0] SP_LBRACK  = 5'd4;
   localparam logic [CODE_W-1:0] SP_RBRACK  = 5'd5;
   localparam logic [CODE_W-1:0] SP_LBRACE  = 5'd6;
   localparam logic [CODE_W-1:0] SP_RBRACE  = 5'd7;
   localparam logic [CODE_W-1:0] SP_ARROW   = 5'd8;
   localparam logic [CODE_W-1:0] SP_NEWLINE = 5'd9;

   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_NAME = 6'b000010,
      MODE_OP   = 6'b000100,
      MODE_STR  = 6'b001000,
      MODE_ESC  = 6'b010000,
      MODE_SKIP = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  len;
   } tok_type;

   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
   } match_type;

   typedef logic [KW_MAX_LEN-1:0][CH_W-1:0] name_buf_type;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      sat_inc = (v == '1) ? v : v + POS_W'(1);
   endfunction

   function automatic logic name_first_char(input logic [CH_W-1:0] c);
      name_first_char = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h24, 8'h5F});
   endfunction

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      is_digit = (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_pair_prefix(input logic [CH_W-1:0] c);
      is_pair_prefix = (c inside {"+", "-", "*", "/", "&", "|", ">", "<", "!", "="});
   endfunction

   // one-character operators and specials, code from the OP_ and SP_ constants
   function automatic match_type single_match(input logic [CH_W-1:0] c);
      match_type m;
      m = '{hit: 1'b1, kind: KIND_OP, code: CODE_NONE};
      case (c)
         "+":     m.code = OP_ADD;
         "-":     m.code = OP_SUB;
         "*":     m.code = OP_MUL;
         "/":     m.code = OP_DIV;
         "=":     m.code = OP_ASSIGN;
         "!":     m.code = OP_NOT;
         ">":     m.code = OP_GT;
         "<":     m.code = OP_LT;
         ".":     begin m.kind = KIND_SPEC; m.code = SP_DOT; end
         ",":     begin m.kind = KIND_SPEC; m.code = SP_COMMA; end
         "(":     begin m.kind = KIND_SPEC; m.code = SP_LPAREN; end
         ")":     begin m.kind = KIND_SPEC; m.code = SP_RPAREN; end
         "[":     begin m.kind = KIND_SPEC; m.code = SP_LBRACK; end
         "]":     begin m.kind = KIND_SPEC; m.code = SP_RBRACK; end
         "{":     begin m.kind = KIND_SPEC; m.code = SP_LBRACE; end
         "}":     begin m.kind = KIND_SPEC; m.code = SP_RBRACE; end
         8'h0A:   begin m.kind = KIND_SPEC; m.code = SP_NEWLINE; end
         default: m.hit = 1'b0;
      endcase
      single_match = m;
   endfunction

   function automatic match_type pair_match(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b);
      match_type m;
      m = '{hit: 1'b1, kind: KIND_OP, code: CODE_NONE};
      case ({a, b})
         {"+", "+"}: m.code = OP_INC;
         {"-", "-"}: m.code = OP_DEC;
         {"+", "="}: m.code = OP_ADD_EQ;
         {"-", "="}: m.code = OP_SUB_EQ;
         {"*", "="}: m.code = OP_MUL_EQ;
         {"/", "="}: m.code = OP_DIV_EQ;
         {"&", "&"}: m.code = OP_AND;
         {"|", "|"}: m.code = OP_OR;
         {">", "="}: m.code = OP_GE;
         {"<", "="}: m.code = OP_LE;
         {"!", "="}: m.code = OP_NE;
         {"=", "="}: m.code = OP_EQ;
         {"=", ">"}: begin m.kind = KIND_SPEC; m.code = SP_ARROW; end
         default:    m.hit = 1'b0;
      endcase
      pair_match = m;
   endfunction

   // name or keyword token from the buffered characters
   function automatic tok_type name_token(input name_buf_type c,
                                          input logic [POS_W-1:0] len,
                                          input logic [POS_W-1:0] start);
      tok_type t;
      t = '{kind: KIND_NAME, code: CODE_NONE, start: start, len: len};
      if (len == POS_W'(2) && c[0] == "i" && c[1] == "f") begin
         t.kind = KIND_KW; t.code = KW_IF;
      end else if (len == POS_W'(3) && c[0] == "f" && c[1] == "o" && c[2] == "r") begin
         t.kind = KIND_KW; t.code = KW_FOR;
      end else if (len == POS_W'(8) && c[0] == "f" && c[1] == "u" && c[2] == "n"
                   && c[3] == "c" && c[4] == "t" && c[5] == "i" && c[6] == "o"
                   && c[7] == "n") begin
         t.kind = KIND_KW; t.code = KW_FUNCTION;
      end else if (len == POS_W'(5) && c[0] == "c" && c[1] == "l" && c[2] == "a"
                   && c[3] == "s" && c[4] == "s") begin
         t.kind = KIND_KW; t.code = KW_CLASS;
      end
      name_token = t;
   endfunction

endpackage

### rtl/script_token_lexer_unit.sv
`timescale 1ns / 1ps

// Streaming tokenizer for script expression text.
// req channel: one text byte per word in req_tdata, req_tlast on the final
// byte of an expression. rsp channel: one token per word, kind in rsp_tuser,
// code, start and length in rsp_tdata, rsp_tlast on the last token caused
// by an input byte. csr channel: writes base_position, always ready; write
// it only while no tokens are pending.
// Each byte is decided in the cycle it is accepted and its tokens (zero, one
// or two) are written into a four-entry result queue, which drives rsp from
// its head. A byte that yields two tokens is drained as two rsp words from
// one queue entry.
// Throughput: one byte per cycle while the queue has room; req_tready drops
// only when the queue holds four entries, i.e. when rsp has been stalled
// long enough, and returns as soon as an entry drains.
// Reset clears the scanner to idle between tokens, position and
// base_position to zero and empties the queue. A name or a possible
// two-character operator is held until the following byte decides it.
module script_token_lexer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stl_pkg::REQ_DATA_W-1:0]    req_tdata,  // ch[7:0]
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // token_code[4:0], start_pos[20:5], token_length[36:21], zero[39:37]
   output logic [stl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [stl_pkg::KIND_W-1:0]        rsp_tuser,  // token_kind[2:0]
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stl_pkg::POS_W-1:0]         csr_data
);
   import stl_pkg::*;

   mode_type             mode_ff, mode_in;
   logic [POS_W-1:0]     base_ff;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     len_ff, len_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CH_W-1:0]      quote_ff, quote_in;
   logic [CH_W-1:0]      pend_ff, pend_in;
   name_buf_type         name_ff;
   logic                 name_we;
   logic [KW_IDX_W-1:0]  name_wa;

   logic [CH_W-1:0]      ch;
   logic                 last;
   logic                 req_fire, rsp_fire;

   // start-of-token decision for the current byte
   mode_type             sc_mode;
   logic                 sc_emit;
   tok_type              sc_tok;
   logic                 sc_set_start, sc_len1, sc_name0, sc_quote, sc_pend;
   match_type            sc_single;

   match_type            pend_pair, pend_single;
   name_buf_type         name_view;
   logic [POS_W-1:0]     len_inc;

   logic                 r0_v, r1_v;
   tok_type              r0, r1;
   logic                 push;

   tok_type              q_r0_ff [Q_DEPTH];
   tok_type              q_r1_ff [Q_DEPTH];
   logic [Q_DEPTH-1:0]   q_two_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   q_count_ff;
   logic                 sub_ff;
   logic                 pop;
   tok_type              head_tok;

   assign ch         = req_tdata[CH_W-1:0];
   assign last       = req_tlast;
   assign req_tready = (q_count_ff != Q_CNT_W'(Q_DEPTH));
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign sc_single   = single_match(ch);
   assign pend_pair   = pair_match(pend_ff, ch);
   assign pend_single = single_match(pend_ff);
   assign len_inc     = sat_inc(len_ff);

   always_comb begin
      sc_mode      = MODE_IDLE;
      sc_emit      = 1'b0;
      sc_tok       = '{kind: KIND_ERR, code: CODE_NONE, start: pos_ff, len: POS_W'(1)};
      sc_set_start = 1'b0;
      sc_len1      = 1'b0;
      sc_name0     = 1'b0;
      sc_quote     = 1'b0;
      sc_pend      = 1'b0;
      if (ch == " " || is_digit(ch)) begin
         sc_mode = MODE_IDLE;
      end else if (sc_single.hit || is_pair_prefix(ch)) begin
         if (!last && is_pair_prefix(ch)) begin
            sc_mode      = MODE_OP;
            sc_pend      = 1'b1;
            sc_set_start = 1'b1;
         end else if (sc_single.hit) begin
            sc_emit     = 1'b1;
            sc_tok.kind = sc_single.kind;
            sc_tok.code = sc_single.code;
         end else begin
            // lone ampersand or bar at the end of text
            sc_emit = 1'b1;
            sc_mode = MODE_SKIP;
         end
      end else if (name_first_char(ch)) begin
         sc_set_start = 1'b1;
         sc_len1      = 1'b1;
         sc_name0     = 1'b1;
         sc_mode      = MODE_NAME;
         if (last) begin
            sc_emit     = 1'b1;
            sc_tok.kind = KIND_NAME;
         end
      end else if (ch == 8'h22 || ch == 8'h27) begin
         sc_set_start = 1'b1;
         sc_len1      = 1'b1;
         sc_quote     = 1'b1;
         sc_mode      = MODE_STR;
         if (last) begin
            sc_emit = 1'b1;
            sc_mode = MODE_SKIP;
         end
      end else begin
         sc_emit = 1'b1;
         sc_mode = MODE_SKIP;
      end
   end

   // buffered name as it reads after this byte is appended
   always_comb begin
      for (int j = 0; j < KW_MAX_LEN; j++) begin
         name_view[j] = (len_ff == POS_W'(j)) ? ch : name_ff[j];
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      quote_in = quote_ff;
      pend_in  = pend_ff;
      name_we  = 1'b0;
      name_wa  = '0;
      r0_v     = 1'b0;
      r1_v     = 1'b0;
      r0       = sc_tok;
      r1       = sc_tok;

      case (mode_ff)
         MODE_NAME: begin
            if (name_first_char(ch) || is_digit(ch)) begin
               if (len_ff < POS_W'(KW_MAX_LEN)) begin
                  name_we = 1'b1;
                  name_wa = len_ff[KW_IDX_W-1:0];
               end
               len_in = len_inc;
               if (last) begin
                  r0_v = 1'b1;
                  r0   = name_token(name_view, len_inc, start_ff);
               end
            end else begin
               r0_v    = 1'b1;
               r0      = name_token(name_ff, len_ff, start_ff);
               r1_v    = sc_emit;
               mode_in = sc_mode;
            end
         end
         MODE_OP: begin
            if (pend_pair.hit) begin
               r0_v    = 1'b1;
               r0      = '{kind: pend_pair.kind, code: pend_pair.code,
                           start: start_ff, len: POS_W'(2)};
               mode_in = MODE_IDLE;
            end else if (pend_single.hit) begin
               r0_v    = 1'b1;
               r0      = '{kind: pend_single.kind, code: pend_single.code,
                           start: start_ff, len: POS_W'(1)};
               r1_v    = sc_emit;
               mode_in = sc_mode;
            end else begin
               r0_v    = 1'b1;
               r0      = '{kind: KIND_ERR, code: CODE_NONE, start: start_ff,
                           len: POS_W'(1)};
               mode_in = MODE_SKIP;
            end
         end
         MODE_STR, MODE_ESC: begin
            len_in = len_inc;
            if (mode_ff == MODE_ESC) begin
               mode_in = MODE_STR;
            end else if (ch == 8'h5C) begin
               mode_in = MODE_ESC;
            end else if (ch == quote_ff) begin
               mode_in = MODE_IDLE;
            end
            if (last && mode_in != MODE_IDLE) begin
               // unterminated string, reported at the opening quote
               r0_v = 1'b1;
               r0   = '{kind: KIND_ERR, code: CODE_NONE, start: start_ff, len: len_inc};
            end
         end
         MODE_SKIP: begin
            mode_in = MODE_SKIP;
         end
         default: begin
            r0_v    = sc_emit;
            mode_in = sc_mode;
         end
      endcase

      // start-of-token side effects only when the byte reached the start path
      if ((mode_ff == MODE_IDLE) || (mode_ff == MODE_NAME && r0_v && !(last &&
          (name_first_char(ch) || is_digit(ch)))) || (mode_ff == MODE_OP &&
          !pend_pair.hit && pend_single.hit)) begin
         if (sc_set_start) start_in = pos_ff;
         if (sc_len1)      len_in   = POS_W'(1);
         if (sc_quote)     quote_in = ch;
         if (sc_pend)      pend_in  = ch;
         if (sc_name0) begin
            name_we = 1'b1;
            name_wa = '0;
         end
      end

      if (last) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         len_in   = '0;
         quote_in = '0;
         pend_in  = '0;
         pos_in   = '0;
      end else begin
         pos_in   = sat_inc(pos_ff);
      end
   end

   assign push = req_fire && r0_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         base_ff  <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         quote_ff <= '0;
         pend_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data;
         end
         if (req_fire) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            pos_ff   <= pos_in;
            quote_ff <= quote_in;
            pend_ff  <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && name_we) begin
         name_ff[name_wa] <= ch;
      end
   end

   // result queue: one entry per token-producing byte, holding one or two tokens
   assign head_tok   = sub_ff ? q_r1_ff[rd_ptr_ff] : q_r0_ff[rd_ptr_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tuser  = head_tok.kind;
   assign rsp_tdata  = RSP_DATA_W'({head_tok.len, head_tok.start, head_tok.code});
   assign rsp_tlast  = sub_ff || !q_two_ff[rd_ptr_ff];
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign pop        = rsp_fire && rsp_tlast;

   always_ff @(posedge clock) begin
      if (push) begin
         q_r0_ff[wr_ptr_ff] <= '{kind: r0.kind, code: r0.code,
                                 start: base_ff + r0.start, len: r0.len};
         q_r1_ff[wr_ptr_ff] <= '{kind: r1.kind, code: r1.code,
                                 start: base_ff + r1.start, len: r1.len};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         q_two_ff   <= '0;
         sub_ff     <= 1'b0;
      end else begin
         if (push) begin
            q_two_ff[wr_ptr_ff] <= r1_v;
            wr_ptr_ff           <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
            sub_ff    <= 1'b0;
         end else if (rsp_fire) begin
            sub_ff <= 1'b1;
         end
         if (push && !pop) begin
            q_count_ff <= q_count_ff + Q_CNT_W'(1);
         end else if (pop && !push) begin
            q_count_ff <= q_count_ff - Q_CNT_W'(1);
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count beyond depth");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff == MODE_SKIP |-> !push)
      else $error("token produced while skipping after an error");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> mode_ff == MODE_IDLE && pos_ff == '0)
      else $error("scanner not back to idle after end of text");

   a_second_only_pairs: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> rsp_tvalid && q_two_ff[rd_ptr_ff])
      else $error("second token shown for a single-token entry");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      req_fire && r1_v |-> r0_v)
      else $error("second token without a first");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import stl_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  len;
      logic              fin;
   } lex_token_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
      logic            typed;
      lex_token_type   tok;
   } stim_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [POS_W-1:0]      csr_data = '0;

   script_token_lexer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // scanner copy
   mode_type          scan = MODE_IDLE;
   logic [CH_W-1:0]   name_buf [KW_MAX_LEN];
   logic [POS_W-1:0]  t_start = '0;
   logic [POS_W-1:0]  t_len = '0;
   logic [POS_W-1:0]  cur_pos = '0;
   logic [POS_W-1:0]  base_pos = '0;
   logic [CH_W-1:0]   quote_ch = '0;
   logic [CH_W-1:0]   held_op = '0;
   int                tokens_added;

   lex_token_type     pending_tokens[$];
   logic [CH_W-1:0]   text_bytes[$];
   int                fail_count = 0;
   int                bytes_sent = 0;
   int                quiet_cycles = 0;
   int                stall_left = 0;
   bit                idle_on = 1'b1;
   bit                squeeze_req = 1'b0;
   bit                squeeze_done = 1'b0;
   lex_token_type     got_tok;
   lex_token_type     want_tok;

   string kw_words[4] = '{"if", "for", "function", "class"};
   logic [CODE_W-1:0] kw_codes[4] = '{KW_IF, KW_FOR, KW_FUNCTION, KW_CLASS};
   string op_words[21] = '{"+", "-", "*", "/", "=", "!", ">", "<", "++", "--", "+=",
                           "-=", "*=", "/=", "&&", "||", ">=", "<=", "!=", "==", "=>"};
   string spec_words[9] = '{".", ",", "(", ")", "[", "]", "{", "}", "\n"};
   string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ$_";
   string name_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ$_0123456789";

   // typed rows carry the token that the byte must produce, base position is zero
   stim_row_type directed_rows[26] = '{
      '{"(",    1'b0, 1'b1, '{KIND_SPEC, SP_LPAREN, 16'd0, 16'd1, 1'b1}},
      '{8'hFF,  1'b1, 1'b1, '{KIND_ERR, CODE_NONE, 16'd1, 16'd1, 1'b1}},
      '{8'h00,  1'b0, 1'b1, '{KIND_ERR, CODE_NONE, 16'd0, 16'd1, 1'b1}},
      '{"a",    1'b0, 1'b0, '0},
      '{"x",    1'b1, 1'b0, '0},
      '{"i",    1'b0, 1'b0, '0},
      '{"f",    1'b0, 1'b0, '0},
      '{" ",    1'b0, 1'b0, '0},
      '{"+",    1'b0, 1'b0, '0},
      '{"+",    1'b0, 1'b0, '0},
      '{"=",    1'b0, 1'b0, '0},
      '{">",    1'b0, 1'b0, '0},
      '{"\"",   1'b0, 1'b0, '0},
      '{"\\",   1'b0, 1'b0, '0},
      '{"\"",   1'b0, 1'b0, '0},
      '{"\"",   1'b0, 1'b0, '0},
      '{"9",    1'b0, 1'b0, '0},
      '{"\n",   1'b0, 1'b0, '0},
      '{"!",    1'b0, 1'b0, '0},
      '{"c",    1'b0, 1'b0, '0},
      '{"+",    1'b1, 1'b0, '0},
      '{"&",    1'b0, 1'b0, '0},
      '{"x",    1'b0, 1'b1, '{KIND_ERR, CODE_NONE, 16'd0, 16'd1, 1'b1}},
      '{"y",    1'b1, 1'b0, '0},
      '{"'",    1'b0, 1'b0, '0},
      '{"a",    1'b1, 1'b1, '{KIND_ERR, CODE_NONE, 16'd0, 16'd2, 1'b1}}
   };

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic bit ident_head(input logic [CH_W-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "$" || c == "_";
   endfunction

   function automatic bit ident_tail(input logic [CH_W-1:0] c);
      return ident_head(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic bit opens_pair(input logic [CH_W-1:0] c);
      case (c)
         "+", "-", "*", "/", "&", "|", ">", "<", "!", "=": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit lone_lookup(input logic [CH_W-1:0] c,
                                      output logic [KIND_W-1:0] k,
                                      output logic [CODE_W-1:0] cd);
      k = KIND_OP;
      cd = OP_ADD;
      case (c)
         "+": cd = OP_ADD;
         "-": cd = OP_SUB;
         "*": cd = OP_MUL;
         "/": cd = OP_DIV;
         "=": cd = OP_ASSIGN;
         "!": cd = OP_NOT;
         ">": cd = OP_GT;
         "<": cd = OP_LT;
         ".": begin k = KIND_SPEC; cd = SP_DOT; end
         ",": begin k = KIND_SPEC; cd = SP_COMMA; end
         "(": begin k = KIND_SPEC; cd = SP_LPAREN; end
         ")": begin k = KIND_SPEC; cd = SP_RPAREN; end
         "[": begin k = KIND_SPEC; cd = SP_LBRACK; end
         "]": begin k = KIND_SPEC; cd = SP_RBRACK; end
         "{": begin k = KIND_SPEC; cd = SP_LBRACE; end
         "}": begin k = KIND_SPEC; cd = SP_RBRACE; end
         "\n": begin k = KIND_SPEC; cd = SP_NEWLINE; end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit pair_lookup(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                      output logic [KIND_W-1:0] k,
                                      output logic [CODE_W-1:0] cd);
      k = KIND_OP;
      cd = OP_INC;
      case ({a, b})
         {"+", "+"}: cd = OP_INC;
         {"-", "-"}: cd = OP_DEC;
         {"+", "="}: cd = OP_ADD_EQ;
         {"-", "="}: cd = OP_SUB_EQ;
         {"*", "="}: cd = OP_MUL_EQ;
         {"/", "="}: cd = OP_DIV_EQ;
         {"&", "&"}: cd = OP_AND;
         {"|", "|"}: cd = OP_OR;
         {">", "="}: cd = OP_GE;
         {"<", "="}: cd = OP_LE;
         {"!", "="}: cd = OP_NE;
         {"=", "="}: cd = OP_EQ;
         {"=", ">"}: begin k = KIND_SPEC; cd = SP_ARROW; end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic void add_token(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] cd,
                                     input logic [POS_W-1:0] s, input logic [POS_W-1:0] n);
      pending_tokens.insert(pending_tokens.size(),
                            '{kind: k, code: cd, start: base_pos + s, len: n, fin: 1'b0});
      tokens_added++;
   endfunction

   function automatic void flag_error(input logic [POS_W-1:0] s, input logic [POS_W-1:0] n);
      add_token(KIND_ERR, CODE_NONE, s, n);
      scan = MODE_SKIP;
   endfunction

   function automatic void close_name();
      logic [KIND_W-1:0] kd;
      logic [CODE_W-1:0] cd;
      bit same;
      kd = KIND_NAME;
      cd = CODE_NONE;
      for (int k = 0; k < 4; k++) begin
         if (kd == KIND_NAME && t_len == POS_W'(kw_words[k].len())) begin
            same = 1'b1;
            for (int j = 0; j < kw_words[k].len(); j++) begin
               if (name_buf[j] != kw_words[k][j]) same = 1'b0;
            end
            if (same) begin
               kd = KIND_KW;
               cd = kw_codes[k];
            end
         end
      end
      add_token(kd, cd, t_start, t_len);
   endfunction

   // byte seen between tokens
   function automatic void open_token(input logic [CH_W-1:0] c, input logic [POS_W-1:0] p,
                                      input logic last);
      logic [KIND_W-1:0] k;
      logic [CODE_W-1:0] cd;
      bit single;
      bit pre;
      single = lone_lookup(c, k, cd);
      pre = opens_pair(c);
      scan = MODE_IDLE;
      if (c == " " || (c >= "0" && c <= "9")) return;
      if (single || pre) begin
         if (!last && pre) begin
            scan = MODE_OP;
            held_op = c;
            t_start = p;
         end else if (single) begin
            add_token(k, cd, p, 1);
         end else begin
            flag_error(p, 1);
         end
         return;
      end
      if (ident_head(c)) begin
         t_start = p;
         t_len = 1;
         name_buf[0] = c;
         scan = MODE_NAME;
         if (last) close_name();
         return;
      end
      if (c == "\"" || c == "'") begin
         t_start = p;
         t_len = 1;
         quote_ch = c;
         scan = MODE_STR;
         if (last) flag_error(t_start, t_len);
         return;
      end
      flag_error(p, 1);
   endfunction

   function automatic int lex_byte(input logic [CH_W-1:0] c, input logic last);
      logic [KIND_W-1:0] k;
      logic [CODE_W-1:0] cd;
      logic [POS_W-1:0]  p;
      p = cur_pos;
      tokens_added = 0;
      case (scan)
         MODE_NAME: begin
            if (ident_tail(c)) begin
               if (t_len < KW_MAX_LEN) name_buf[t_len[KW_IDX_W-1:0]] = c;
               t_len = pos_inc(t_len);
               if (last) close_name();
            end else begin
               close_name();
               open_token(c, p, last);
            end
         end
         MODE_OP: begin
            if (pair_lookup(held_op, c, k, cd)) begin
               add_token(k, cd, t_start, 2);
               scan = MODE_IDLE;
            end else if (lone_lookup(held_op, k, cd)) begin
               add_token(k, cd, t_start, 1);
               open_token(c, p, last);
            end else begin
               // lone ampersand or bar
               flag_error(t_start, 1);
            end
         end
         MODE_STR, MODE_ESC: begin
            t_len = pos_inc(t_len);
            if (scan == MODE_ESC) scan = MODE_STR;
            else if (c == "\\") scan = MODE_ESC;
            else if (c == quote_ch) scan = MODE_IDLE;
            if (last && scan != MODE_IDLE) flag_error(t_start, t_len);
         end
         MODE_SKIP: ;
         default: open_token(c, p, last);
      endcase
      if (last) begin
         scan = MODE_IDLE;
         t_start = '0;
         t_len = '0;
         cur_pos = '0;
         quote_ch = '0;
         held_op = '0;
      end else begin
         cur_pos = pos_inc(cur_pos);
      end
      if (tokens_added > 0) pending_tokens[pending_tokens.size() - 1].fin = 1'b1;
      return tokens_added;
   endfunction

   task automatic push_byte(input logic [CH_W-1:0] c, input logic last, output int made);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      made = lex_byte(c, last);
      bytes_sent++;
   endtask

   task automatic write_base(input logic [POS_W-1:0] v);
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      base_pos = v;
   endtask

   function automatic void add_byte(input logic [CH_W-1:0] c);
      text_bytes.insert(text_bytes.size(), c);
   endfunction

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // one expression built mostly from legal tokens, with some noise
   task automatic compose_text();
      string w;
      int n;
      logic [CH_W-1:0] q;
      text_bytes.delete();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               w = kw_words[$urandom_range(0, 3)];
               case ($urandom_range(0, 3))
                  0: w = w.substr(0, w.len() - 2);
                  1: w = {w, "s"};
                  default: ;
               endcase
               add_chars(w);
            end
            2, 3: begin
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
               add_byte(name_head[$urandom_range(0, name_head.len() - 1)]);
               repeat (n - 1) add_byte(name_tail[$urandom_range(0, name_tail.len() - 1)]);
            end
            4, 5, 6, 7, 8: add_chars(op_words[$urandom_range(0, $size(op_words) - 1)]);
            9, 10, 11: add_chars(spec_words[$urandom_range(0, $size(spec_words) - 1)]);
            12, 13: begin
               repeat ($urandom_range(1, 4)) add_byte(CH_W'($urandom_range(48, 57)));
            end
            14, 15: begin
               q = ($urandom_range(0, 1) == 0) ? "\"" : "'";
               add_byte(q);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 5) == 0) add_byte("\\");
                  add_byte(CH_W'($urandom_range(32, 126)));
               end
               if ($urandom_range(0, 7) != 0) add_byte(q);
            end
            16, 17, 18: repeat ($urandom_range(1, 3)) add_byte(" ");
            default: begin
               case ($urandom_range(0, 3))
                  0: add_byte(CH_W'($urandom_range(0, 255)));
                  1: add_byte("&");
                  2: add_byte("|");
                  default: add_byte(8'h09);
               endcase
            end
         endcase
      end
   endtask

   task automatic random_text(input int goal);
      int made;
      goal = bytes_sent + goal;
      while (bytes_sent < goal) begin
         compose_text();
         for (int i = 0; i < text_bytes.size(); i++)
            push_byte(text_bytes[i], i == text_bytes.size() - 1, made);
      end
   endtask

   initial begin : main_flow
      int made;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < $size(directed_rows); r++) begin
         push_byte(directed_rows[r].ch, directed_rows[r].last, made);
         if (directed_rows[r].typed) begin
            repeat (made) void'(pending_tokens.pop_back());
            pending_tokens.insert(pending_tokens.size(), directed_rows[r].tok);
         end
      end

      // start positions wrap with the top base
      write_base(16'hFFFF);
      idle_on = 1'b0;
      push_byte("\"", 1'b0, made);
      repeat (3) push_byte("a", 1'b0, made);
      push_byte("a", 1'b1, made);
      repeat (3) push_byte("b", 1'b0, made);
      push_byte(" ", 1'b0, made);
      push_byte("x", 1'b1, made);

      write_base(16'h0000);
      idle_on = 1'b1;
      random_text(700);
      write_base(POS_W'($urandom));
      squeeze_req = 1'b1;
      random_text(700);
      write_base(16'h8001);
      idle_on = 1'b0;
      random_text(600);
      req_tvalid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("script_token_lexer_unit regression: pass");
      end else begin
         $display("script_token_lexer_unit regression: fail");
      end
      $finish;
   end

   // receiver back-pressure, one long hold once the squeeze is requested
   always @(posedge clock) begin
      if (squeeze_req && !squeeze_done) begin
         squeeze_done = 1'b1;
         stall_left = 64;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // a word is taken at the next rising edge when valid and ready are high here
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_tok = {rsp_tuser, rsp_tdata[4:0], rsp_tdata[20:5], rsp_tdata[36:21], rsp_tlast};
         if (pending_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= 50)
               $display("%0t: unexpected token kind %0d code %0d start %0d len %0d last %0d",
                        $time, got_tok.kind, got_tok.code, got_tok.start, got_tok.len,
                        got_tok.fin);
         end else begin
            want_tok = pending_tokens.pop_front();
            if (got_tok !== want_tok) begin
               fail_count++;
               if (fail_count <= 50)
                  $display({"%0t: token mismatch, expected kind %0d code %0d start %0d ",
                            "len %0d last %0d, got kind %0d code %0d start %0d len %0d ",
                            "last %0d"},
                           $time, want_tok.kind, want_tok.code, want_tok.start,
                           want_tok.len, want_tok.fin, got_tok.kind, got_tok.code,
                           got_tok.start, got_tok.len, got_tok.fin);
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("script_token_lexer_unit regression: fail");
         $finish;
      end
   end

endmodule
